// ===== design/ray_triangle_occlusion_top_macros.svh =====
// assertion macros used by the checker file
`ifndef RAY_TRIANGLE_OCCLUSION_TOP_MACROS_SVH
`define RAY_TRIANGLE_OCCLUSION_TOP_MACROS_SVH

// same-cycle implication under the block reset
`define RTO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rto check failed");

// next-cycle implication under the block reset
`define RTO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rto check failed");

`endif

// ===== design/rto_pkg.sv =====
// types, constants and microcode table of the ray/triangle occlusion block
package rto_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 24;
  localparam int EW        = CW + 1;
  localparam int PW        = 16;
  localparam int VAL_W     = 80;
  localparam int HQ_W      = 52;
  localparam int ACC_W     = 98;
  localparam int OPA_W     = 26;
  localparam int OPB_W     = 29;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int CHUNK     = 26;
  localparam int MF_FRAC   = 16;
  localparam int NUM_STEPS = 41;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam int IN_W      = 9 * CW;
  localparam int OUT_W     = 8;

  localparam logic signed [CW-1:0] TARGET_X_RST = CW'(0);
  localparam logic signed [CW-1:0] TARGET_Y_RST = CW'(0);
  localparam logic signed [CW-1:0] TARGET_Z_RST = CW'(65536);
  localparam logic [PW-1:0]        DET_EPS_RST  = PW'(1);
  localparam logic [PW-1:0]        MIN_FRAC_RST = PW'(655);

  typedef enum logic [2:0] {
    REG_TARGET_X, REG_TARGET_Y, REG_TARGET_Z, REG_DET_EPS, REG_MIN_FRAC
  } cfg_reg_e;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DECIDE} state_e;

  typedef enum logic [1:0] {K_MAC, K_NEG_DET, K_LOAD_NT} kind_e;

  typedef enum logic [3:0] {
    A_RX, A_RY, A_RZ, A_E1X, A_E1Y, A_E1Z, A_E2X, A_E2Y, A_E2Z,
    A_SX, A_SY, A_SZ, A_MF
  } asel_e;

  typedef enum logic [3:0] {
    B_E1X, B_E1Y, B_E1Z, B_E2X, B_E2Y, B_E2Z,
    B_HX, B_HY, B_HZ, B_QX, B_QY, B_QZ, B_DET
  } bsel_e;

  typedef enum logic [2:0] {M_LO_S, M_LO_U, M_MID_U, M_MID_S, M_HI_S} mode_e;

  typedef enum logic [3:0] {
    D_NONE, D_HX, D_HY, D_HZ, D_QX, D_QY, D_QZ, D_DET, D_NU, D_NV, D_NT
  } dest_e;

  typedef struct packed {
    kind_e kind;
    asel_e asel;
    bsel_e bsel;
    mode_e mode;
    logic  sub;
    logic  clr;
    logic  inv;
    dest_e dest;
  } uop_t;

  typedef struct packed {
    logic load;
    logic run;
    logic emit;
    uop_t uop;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic par;
  } status_t;

  function automatic uop_t mk(kind_e k, asel_e a, bsel_e b, mode_e m,
                              logic sub, logic clr, logic inv, dest_e d);
    uop_t u;
    u.kind = k;
    u.asel = a;
    u.bsel = b;
    u.mode = m;
    u.sub  = sub;
    u.clr  = clr;
    u.inv  = inv;
    u.dest = d;
    return u;
  endfunction

  // h = ray x e2, q = s x e1, det = e1.h, nu = s.h, nv = ray.q, nt = e2.q,
  // then acc = nt*2^16 - det*min_fraction
  function automatic uop_t step_uop(logic [STEP_W-1:0] idx);
    uop_t u;
    unique case (idx)
      6'd0:  u = mk(K_MAC, A_RY, B_E2Z, M_LO_S, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd1:  u = mk(K_MAC, A_RZ, B_E2Y, M_LO_S, 1'b1, 1'b0, 1'b0, D_HX);
      6'd2:  u = mk(K_MAC, A_RZ, B_E2X, M_LO_S, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd3:  u = mk(K_MAC, A_RX, B_E2Z, M_LO_S, 1'b1, 1'b0, 1'b0, D_HY);
      6'd4:  u = mk(K_MAC, A_RX, B_E2Y, M_LO_S, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd5:  u = mk(K_MAC, A_RY, B_E2X, M_LO_S, 1'b1, 1'b0, 1'b0, D_HZ);
      6'd6:  u = mk(K_MAC, A_SY, B_E1Z, M_LO_S, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd7:  u = mk(K_MAC, A_SZ, B_E1Y, M_LO_S, 1'b1, 1'b0, 1'b0, D_QX);
      6'd8:  u = mk(K_MAC, A_SZ, B_E1X, M_LO_S, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd9:  u = mk(K_MAC, A_SX, B_E1Z, M_LO_S, 1'b1, 1'b0, 1'b0, D_QY);
      6'd10: u = mk(K_MAC, A_SX, B_E1Y, M_LO_S, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd11: u = mk(K_MAC, A_SY, B_E1X, M_LO_S, 1'b1, 1'b0, 1'b0, D_QZ);
      6'd12: u = mk(K_MAC, A_E1X, B_HX, M_LO_U, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd13: u = mk(K_MAC, A_E1X, B_HX, M_MID_S, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd14: u = mk(K_MAC, A_E1Y, B_HY, M_LO_U, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd15: u = mk(K_MAC, A_E1Y, B_HY, M_MID_S, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd16: u = mk(K_MAC, A_E1Z, B_HZ, M_LO_U, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd17: u = mk(K_MAC, A_E1Z, B_HZ, M_MID_S, 1'b0, 1'b0, 1'b0, D_DET);
      6'd18: u = mk(K_NEG_DET, A_MF, B_DET, M_LO_U, 1'b0, 1'b1, 1'b0, D_DET);
      6'd19: u = mk(K_MAC, A_SX, B_HX, M_LO_U, 1'b0, 1'b1, 1'b1, D_NONE);
      6'd20: u = mk(K_MAC, A_SX, B_HX, M_MID_S, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd21: u = mk(K_MAC, A_SY, B_HY, M_LO_U, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd22: u = mk(K_MAC, A_SY, B_HY, M_MID_S, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd23: u = mk(K_MAC, A_SZ, B_HZ, M_LO_U, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd24: u = mk(K_MAC, A_SZ, B_HZ, M_MID_S, 1'b0, 1'b0, 1'b1, D_NU);
      6'd25: u = mk(K_MAC, A_RX, B_QX, M_LO_U, 1'b0, 1'b1, 1'b1, D_NONE);
      6'd26: u = mk(K_MAC, A_RX, B_QX, M_MID_S, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd27: u = mk(K_MAC, A_RY, B_QY, M_LO_U, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd28: u = mk(K_MAC, A_RY, B_QY, M_MID_S, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd29: u = mk(K_MAC, A_RZ, B_QZ, M_LO_U, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd30: u = mk(K_MAC, A_RZ, B_QZ, M_MID_S, 1'b0, 1'b0, 1'b1, D_NV);
      6'd31: u = mk(K_MAC, A_E2X, B_QX, M_LO_U, 1'b0, 1'b1, 1'b1, D_NONE);
      6'd32: u = mk(K_MAC, A_E2X, B_QX, M_MID_S, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd33: u = mk(K_MAC, A_E2Y, B_QY, M_LO_U, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd34: u = mk(K_MAC, A_E2Y, B_QY, M_MID_S, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd35: u = mk(K_MAC, A_E2Z, B_QZ, M_LO_U, 1'b0, 1'b0, 1'b1, D_NONE);
      6'd36: u = mk(K_MAC, A_E2Z, B_QZ, M_MID_S, 1'b0, 1'b0, 1'b1, D_NT);
      6'd37: u = mk(K_LOAD_NT, A_MF, B_DET, M_LO_U, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd38: u = mk(K_MAC, A_MF, B_DET, M_LO_U, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd39: u = mk(K_MAC, A_MF, B_DET, M_MID_U, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd40: u = mk(K_MAC, A_MF, B_DET, M_HI_S, 1'b1, 1'b0, 1'b0, D_NONE);
      default: u = mk(K_MAC, A_MF, B_DET, M_LO_U, 1'b0, 1'b0, 1'b0, D_NONE);
    endcase
    return u;
  endfunction

endpackage

// ===== design/ray_triangle_occlusion_top.sv =====
// top level of the ray/triangle occlusion test
//
//   channel  dir  handshake                     content
//   s_axis   in   s_axis_tvalid/s_axis_tready   one triangle, tlast = last of query
//   m_axis   out  m_axis_tvalid/m_axis_tready   one verdict per triangle
//   cfg      in   cfg_valid_i/cfg_ready_o       register index and write data
//
// a triangle passes from request to result through an accept state, 41
// steps of the shared 26x29 multiply-accumulate unit, and a decision state.
// the multiplier is the bottleneck; the next request is taken once the
// decision state has passed, even while the previous result still waits.
// reset clears the sequencer, the sticky occluded flag and the output valid,
// and restores the configuration registers; the decision stalls while a
// result is still held on m_axis.
module ray_triangle_occlusion_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // ax, ay, az, bx, by_coord, bz, cx_coord, cy_coord, cz_coord (24 bits each)
  input  logic [rto_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit, parallel, occluded, then zero fill
  output logic [rto_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [rto_pkg::CW-1:0]      cfg_data_i
);
  import rto_pkg::*;

  // configuration registers
  logic signed [CW-1:0] target_x_q, target_y_q, target_z_q;
  logic [PW-1:0]        det_eps_q, min_frac_q;

  // output stage and query state
  logic  out_valid_q, out_hit_q, out_par_q, out_occ_q, out_last_q;
  logic  occ_q, last_q;
  logic  occ_now;
  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q <= TARGET_X_RST;
      target_y_q <= TARGET_Y_RST;
      target_z_q <= TARGET_Z_RST;
      det_eps_q  <= DET_EPS_RST;
      min_frac_q <= MIN_FRAC_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TARGET_X: target_x_q <= cfg_data_i;
        REG_TARGET_Y: target_y_q <= cfg_data_i;
        REG_TARGET_Z: target_z_q <= cfg_data_i;
        REG_DET_EPS:  det_eps_q  <= cfg_data_i[PW-1:0];
        REG_MIN_FRAC: min_frac_q <= cfg_data_i[PW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // sequencer: waits for a request, walks the steps, holds for the output
  rto_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_valid_q && !m_axis_tready),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // datapath: operands, shared multiplier/accumulator, final compares
  rto_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .ax_i     (s_axis_tdata[0*CW +: CW]),
    .ay_i     (s_axis_tdata[1*CW +: CW]),
    .az_i     (s_axis_tdata[2*CW +: CW]),
    .bx_i     (s_axis_tdata[3*CW +: CW]),
    .by_i     (s_axis_tdata[4*CW +: CW]),
    .bz_i     (s_axis_tdata[5*CW +: CW]),
    .cx_i     (s_axis_tdata[6*CW +: CW]),
    .cy_i     (s_axis_tdata[7*CW +: CW]),
    .cz_i     (s_axis_tdata[8*CW +: CW]),
    .rx_i     (target_x_q),
    .ry_i     (target_y_q),
    .rz_i     (target_z_q),
    .eps_i    (det_eps_q),
    .mf_i     (min_frac_q),
    .status_o (status)
  );

  // last flag travels with the request
  always_ff @(posedge clk_i) begin
    if (ctrl.load) last_q <= s_axis_tlast;
  end

  assign occ_now = occ_q | status.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      occ_q       <= 1'b0;
    end else begin
      if (ctrl.emit) begin
        out_valid_q <= 1'b1;
        // sticky flag clears once the last triangle of a query is reported
        occ_q       <= last_q ? 1'b0 : occ_now;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_hit_q  <= status.hit;
      out_par_q  <= status.par;
      out_occ_q  <= occ_now;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-3){1'b0}}, out_occ_q, out_par_q, out_hit_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== design/rto_seq.sv =====
// step sequencer that walks the microcode for one triangle
module rto_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_busy_i,
  output logic           in_ready_o,
  output rto_pkg::ctrl_t ctrl_o
);
  import rto_pkg::*;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_STEPS - 1)) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_busy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    ctrl_o.load = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.run  = (state_q == ST_RUN);
    ctrl_o.emit = (state_q == ST_DECIDE) && !out_busy_i;
    ctrl_o.uop  = step_uop(step_q);
  end

endmodule

// ===== design/rto_mac.sv =====
// operand registers, shared multiply-accumulate unit and hit decision
module rto_mac (
  input  logic                          clk_i,
  input  rto_pkg::ctrl_t                ctrl_i,
  input  logic signed [rto_pkg::CW-1:0] ax_i,
  input  logic signed [rto_pkg::CW-1:0] ay_i,
  input  logic signed [rto_pkg::CW-1:0] az_i,
  input  logic signed [rto_pkg::CW-1:0] bx_i,
  input  logic signed [rto_pkg::CW-1:0] by_i,
  input  logic signed [rto_pkg::CW-1:0] bz_i,
  input  logic signed [rto_pkg::CW-1:0] cx_i,
  input  logic signed [rto_pkg::CW-1:0] cy_i,
  input  logic signed [rto_pkg::CW-1:0] cz_i,
  input  logic signed [rto_pkg::CW-1:0] rx_i,
  input  logic signed [rto_pkg::CW-1:0] ry_i,
  input  logic signed [rto_pkg::CW-1:0] rz_i,
  input  logic        [rto_pkg::PW-1:0] eps_i,
  input  logic        [rto_pkg::PW-1:0] mf_i,
  output rto_pkg::status_t              status_o
);
  import rto_pkg::*;

  logic signed [EW-1:0]     e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q, sx_q, sy_q, sz_q;
  logic signed [HQ_W-1:0]   hx_q, hy_q, hz_q, qx_q, qy_q, qz_q;
  logic signed [VAL_W-1:0]  det_q, nu_q, nv_q, nt_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     neg_q;

  logic signed [OPA_W-1:0]  a_op;
  logic signed [VAL_W-1:0]  b_full;
  logic signed [OPB_W-1:0]  b_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, addend, base, sum;
  logic                     eff_sub;
  uop_t                     u;

  logic signed [VAL_W-1:0]  thr;
  logic signed [VAL_W:0]    uv_sum, det_wide;

  assign u = ctrl_i.uop;

  // triangle edges and origin offset, captured when the request is taken
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      e1x_q <= EW'(bx_i) - EW'(ax_i);
      e1y_q <= EW'(by_i) - EW'(ay_i);
      e1z_q <= EW'(bz_i) - EW'(az_i);
      e2x_q <= EW'(cx_i) - EW'(ax_i);
      e2y_q <= EW'(cy_i) - EW'(ay_i);
      e2z_q <= EW'(cz_i) - EW'(az_i);
      sx_q  <= -EW'(ax_i);
      sy_q  <= -EW'(ay_i);
      sz_q  <= -EW'(az_i);
    end
  end

  always_comb begin
    unique case (u.asel)
      A_RX:    a_op = OPA_W'(rx_i);
      A_RY:    a_op = OPA_W'(ry_i);
      A_RZ:    a_op = OPA_W'(rz_i);
      A_E1X:   a_op = OPA_W'(e1x_q);
      A_E1Y:   a_op = OPA_W'(e1y_q);
      A_E1Z:   a_op = OPA_W'(e1z_q);
      A_E2X:   a_op = OPA_W'(e2x_q);
      A_E2Y:   a_op = OPA_W'(e2y_q);
      A_E2Z:   a_op = OPA_W'(e2z_q);
      A_SX:    a_op = OPA_W'(sx_q);
      A_SY:    a_op = OPA_W'(sy_q);
      A_SZ:    a_op = OPA_W'(sz_q);
      A_MF:    a_op = $signed({{(OPA_W-PW){1'b0}}, mf_i});
      default: a_op = '0;
    endcase
  end

  always_comb begin
    unique case (u.bsel)
      B_E1X:   b_full = VAL_W'(e1x_q);
      B_E1Y:   b_full = VAL_W'(e1y_q);
      B_E1Z:   b_full = VAL_W'(e1z_q);
      B_E2X:   b_full = VAL_W'(e2x_q);
      B_E2Y:   b_full = VAL_W'(e2y_q);
      B_E2Z:   b_full = VAL_W'(e2z_q);
      B_HX:    b_full = VAL_W'(hx_q);
      B_HY:    b_full = VAL_W'(hy_q);
      B_HZ:    b_full = VAL_W'(hz_q);
      B_QX:    b_full = VAL_W'(qx_q);
      B_QY:    b_full = VAL_W'(qy_q);
      B_QZ:    b_full = VAL_W'(qz_q);
      B_DET:   b_full = det_q;
      default: b_full = '0;
    endcase
  end

  // pick a slice of the wide operand; the _S modes keep the sign, the _U modes zero-extend
  always_comb begin
    unique case (u.mode)
      M_LO_S:  b_op = b_full[OPB_W-1:0];
      M_LO_U:  b_op = $signed({{(OPB_W-CHUNK){1'b0}}, b_full[CHUNK-1:0]});
      M_MID_U: b_op = $signed({{(OPB_W-CHUNK){1'b0}}, b_full[2*CHUNK-1:CHUNK]});
      M_MID_S: b_op = b_full[CHUNK+OPB_W-1:CHUNK];
      M_HI_S:  b_op = $signed({{(OPB_W-(VAL_W-2*CHUNK)){b_full[VAL_W-1]}},
                               b_full[VAL_W-1:2*CHUNK]});
      default: b_op = '0;
    endcase
  end

  assign prod     = a_op * b_op;
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    unique case (u.kind)
      K_NEG_DET: addend = ACC_W'(det_q);
      K_LOAD_NT: addend = ACC_W'(nt_q) <<< MF_FRAC;
      default: begin
        priority case (u.mode)
          M_MID_U, M_MID_S: addend = prod_ext <<< CHUNK;
          M_HI_S:           addend = prod_ext <<< (2 * CHUNK);
          default:          addend = prod_ext;
        endcase
      end
    endcase
    // numerators follow the sign of det so all later tests see det > 0
    if (u.kind == K_NEG_DET) eff_sub = neg_q;
    else                     eff_sub = u.sub ^ (u.inv & neg_q);
    base = u.clr ? '0 : acc_q;
    sum  = eff_sub ? (base - addend) : (base + addend);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.run) begin
      acc_q <= sum;
      if (u.kind == K_MAC && u.dest == D_DET) neg_q <= sum[VAL_W-1];
      unique case (u.dest)
        D_HX:    hx_q  <= sum[HQ_W-1:0];
        D_HY:    hy_q  <= sum[HQ_W-1:0];
        D_HZ:    hz_q  <= sum[HQ_W-1:0];
        D_QX:    qx_q  <= sum[HQ_W-1:0];
        D_QY:    qy_q  <= sum[HQ_W-1:0];
        D_QZ:    qz_q  <= sum[HQ_W-1:0];
        D_DET:   det_q <= sum[VAL_W-1:0];
        D_NU:    nu_q  <= sum[VAL_W-1:0];
        D_NV:    nv_q  <= sum[VAL_W-1:0];
        D_NT:    nt_q  <= sum[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // decision on the finished numerators; acc holds nt*2^16 - det*min_fraction
  always_comb begin
    thr      = $signed({{(VAL_W-PW-2*FRAC_BITS){1'b0}}, eps_i, {(2*FRAC_BITS){1'b0}}});
    uv_sum   = (VAL_W+1)'(nu_q) + (VAL_W+1)'(nv_q);
    det_wide = (VAL_W+1)'(det_q);
    status_o.par = (det_q == '0) || (det_q < thr);
    status_o.hit = !status_o.par && !nu_q[VAL_W-1] && (nu_q <= det_q)
                   && !nv_q[VAL_W-1] && (uv_sum <= det_wide) && (nt_q < det_q)
                   && !acc_q[ACC_W-1] && (acc_q != '0);
  end

endmodule

// ===== design/rto_checker.sv =====
// port-level checks of the occlusion block, bound to the top level
module rto_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rto_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
`include "ray_triangle_occlusion_top_macros.svh"

  // one triangle at a time: busy right after a request is taken
  `RTO_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a held result stays put
  `RTO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // a skipped triangle never hits
  `RTO_ASSERT_NOW(a_par_no_hit, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))

  // a hit always shows in the running occluded flag
  `RTO_ASSERT_NOW(a_hit_occ, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[2])

endmodule

bind ray_triangle_occlusion_top rto_checker u_rto_checker (.*);
